[hw/rtl/sat_pkg.sv]
// Shared types and codes of the sorted arc table.
package sat_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned VertW  = 32;
  localparam int unsigned EntryW = 2 * KeyW;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_QUERY  = 1'b1
  } sat_req_e;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_MATCH    = 2'd2,
    STATUS_NOMATCH  = 2'd3
  } sat_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_LAST,
    ST_QRY_CMP,
    ST_QRY_FLUSH,
    ST_RESP
  } sat_state_e;

  typedef struct packed {
    sat_req_e          req_type;
    logic [KeyW-1:0]   from_key;
    logic [KeyW-1:0]   to_key;
  } sat_req_t;

  typedef struct packed {
    sat_status_e       status;
    logic [KeyW-1:0]   arc_source;
    logic [KeyW-1:0]   arc_target;
    logic              last;
  } sat_rsp_t;

endpackage

[hw/rtl/sat_if.sv]
// Request and result channel interfaces of the sorted arc table.
interface sat_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] from_key;
  logic [63:0] to_key;

  modport source (output valid, output req_type, output from_key, output to_key, input ready);
  modport sink   (input valid, input req_type, input from_key, input to_key, output ready);
endinterface

interface sat_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] arc_source;
  logic [63:0] arc_target;
  logic        last;

  modport source (output valid, output status, output arc_source, output arc_target,
                  output last, input ready);
  modport sink   (input valid, input status, input arc_source, input arc_target,
                  input last, output ready);
endinterface

[hw/rtl/sat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sat_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sat_ctrl.sv]
// Sequencer of the sorted arc table: insert shift scan and query range scan over the arc RAM.
module sat_ctrl import sat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  sat_req_t req_i,
  output logic     emit_valid_o,
  input  logic     emit_ready_i,
  output sat_rsp_t emit_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  sat_state_e        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     hole_q, hole_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              pend_v_q, pend_v_d;
  logic [EntryW-1:0] pend_q, pend_d;
  logic [KeyW-1:0]   from_q, from_d;
  logic [KeyW-1:0]   to_q, to_d;
  sat_status_e       status_q, status_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  logic [KeyW-1:0]   rd_src;
  logic              ins_less, q_ge, q_match, q_last_idx, q_adv, full;
  logic [CW-1:0]     cnt_m1, hole_m2;

  sat_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_src     = ram_rdata[EntryW-1:KeyW];
  assign ins_less   = {from_q, to_q} < ram_rdata;
  assign q_ge       = rd_src >= from_q;
  assign q_match    = q_ge && (rd_src[KeyW-1:KeyW-VertW] == from_q[KeyW-1:KeyW-VertW]);
  assign q_last_idx = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign q_adv      = !pend_v_q || emit_ready_i;
  assign full       = cnt_q == CW'(TABLE_DEPTH);
  assign cnt_m1     = cnt_q - CW'(1);
  assign hole_m2    = hole_q - CW'(2);

  // Next state and datapath registers.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    hole_d   = hole_q;
    idx_d    = idx_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    from_d   = from_q;
    to_d     = to_q;
    status_d = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          from_d   = req_i.from_key;
          to_d     = req_i.to_key;
          pend_v_d = 1'b0;
          idx_d    = '0;
          hole_d   = cnt_q;
          if (req_i.req_type == REQ_INSERT) begin
            if (full) begin
              status_d = STATUS_FULL;
              state_d  = ST_RESP;
            end else if (cnt_q == '0) begin
              state_d = ST_INS_LAST;
            end else begin
              state_d = ST_INS_CMP;
            end
          end else if (cnt_q == '0) begin
            status_d = STATUS_NOMATCH;
            state_d  = ST_RESP;
          end else begin
            state_d = ST_QRY_CMP;
          end
        end
      end
      ST_INS_CMP: begin
        if (ins_less) begin
          // stored arc sorts after the new one: move it up and keep scanning down
          hole_d = hole_q - CW'(1);
          if (hole_q == CW'(1)) begin
            state_d = ST_INS_LAST;
          end
        end else begin
          cnt_d    = cnt_q + CW'(1);
          status_d = STATUS_INSERTED;
          state_d  = ST_RESP;
        end
      end
      ST_INS_LAST: begin
        cnt_d    = cnt_q + CW'(1);
        status_d = STATUS_INSERTED;
        state_d  = ST_RESP;
      end
      ST_QRY_CMP: begin
        if (q_adv) begin
          if (q_match) begin
            pend_d   = ram_rdata;
            pend_v_d = 1'b1;
            if (q_last_idx) begin
              state_d = ST_QRY_FLUSH;
            end else begin
              idx_d = idx_q + AW'(1);
            end
          end else if (pend_v_q) begin
            state_d = ST_IDLE;
          end else if (q_ge || q_last_idx) begin
            status_d = STATUS_NOMATCH;
            state_d  = ST_RESP;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      ST_QRY_FLUSH: begin
        if (emit_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (emit_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // RAM access and result outputs.
  always_comb begin
    req_ready_o  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = hole_q[AW-1:0];
    ram_wdata    = {from_q, to_q};
    ram_raddr    = idx_q;
    emit_valid_o = 1'b0;
    emit_o       = '{status: STATUS_MATCH, arc_source: pend_q[EntryW-1:KeyW],
                     arc_target: pend_q[KeyW-1:0], last: 1'b1};
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        ram_raddr   = (req_i.req_type == REQ_INSERT) ? cnt_m1[AW-1:0] : '0;
      end
      ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_raddr = hole_m2[AW-1:0];
        if (ins_less) begin
          ram_wdata = ram_rdata;
        end
      end
      ST_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      ST_QRY_CMP: begin
        ram_raddr    = idx_d;
        emit_valid_o = pend_v_q;
        emit_o.last  = !q_match;
      end
      ST_QRY_FLUSH: begin
        emit_valid_o = 1'b1;
      end
      ST_RESP: begin
        emit_valid_o = 1'b1;
        emit_o       = '{status: status_q, arc_source: '0, arc_target: '0, last: 1'b1};
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      hole_q   <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      status_q <= STATUS_INSERTED;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hole_q   <= hole_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    from_q <= from_d;
    to_q   <= to_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("arc count exceeds table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("arc count moved by other than one");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_INS_CMP || state_q == ST_INS_LAST))
    else $error("arc RAM written outside an insert");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_CMP && ins_less && hole_q > CW'(1)) |-> (ram_raddr != ram_waddr))
    else $error("insert shift reads and writes the same entry");

  a_count_grows_after_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && status_q == STATUS_INSERTED && $past(state_q) != ST_RESP)
    |-> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("inserted status without a new arc");

endmodule

[hw/rtl/sorted_arc_table_unit.sv]
// Top level of the sorted arc table: request channel, sequencer and result register.
//
// Keeps up to TABLE_DEPTH graph arcs in one RAM, sorted by (source key, target key);
// equal arcs stay in arrival order. An insert answers one item, status inserted or
// table full (arc dropped). A query answers, in table order, every arc whose source
// vertex (bits 63..32) equals the query vertex and whose source key is at or above the
// query key, the final one marked last; with no match it answers one no-match item.
// One request is in flight at a time; the request channel is ready only while the
// sequencer is idle. The single RAM read port scans one entry per cycle, but a query
// scan holds while the result side stalls. Arc storage needs no clearing after reset:
// the fill count bounds every read.
module sorted_arc_table_unit import sat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sat_req_if.sink   req_i,
  sat_rsp_if.source rsp_o
);

  sat_req_t req;
  sat_rsp_t emit, out_q, out_d;
  logic     emit_valid, emit_ready;
  logic     out_v_q, out_v_d;

  // Pack the request payload for the sequencer.
  assign req = '{req_type: sat_req_e'(req_i.req_type), from_key: req_i.from_key,
                 to_key: req_i.to_key};

  sat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_i        (req),
    .emit_valid_o (emit_valid),
    .emit_ready_i (emit_ready),
    .emit_o       (emit)
  );

  // Result register: take a new item when empty or when the held one drains.
  assign emit_ready = !out_v_q || rsp_o.ready;

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (emit_valid && emit_ready) begin
      out_v_d = 1'b1;
      out_d   = emit;
    end else if (rsp_o.ready) begin
      // drop the delivered item
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.arc_source = out_q.arc_source;
  assign rsp_o.arc_target = out_q.arc_target;
  assign rsp_o.last       = out_q.last;

endmodule

[sim/sat_arc_monitor.sv]
// Arc table monitor: predicts each request's result items and compares them on the result channel.
`timescale 1ns / 100ps

module sat_arc_monitor import sat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sat_req_if          req_i,
  sat_rsp_if          rsp_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned results_due_o
);

  typedef struct packed {
    logic [KeyW-1:0] src;
    logic [KeyW-1:0] dst;
  } arc_t;

  arc_t        arc_tab [TABLE_DEPTH];
  int unsigned arc_total = 0;
  sat_rsp_t    results_due_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned due_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign results_due_o  = due_cnt;

  function automatic sat_rsp_t make_result(sat_status_e status, logic [KeyW-1:0] src,
                                           logic [KeyW-1:0] dst, logic last);
    sat_rsp_t r;
    r.status     = status;
    r.arc_source = src;
    r.arc_target = dst;
    r.last       = last;
    return r;
  endfunction

  // Append one expected result item.
  function automatic void queue_result(sat_rsp_t r);
    results_due_q = {results_due_q, r};
  endfunction

  // (a.src, a.dst) strictly below (b.src, b.dst)
  function automatic logic sorts_before(arc_t a, arc_t b);
    return (a.src < b.src) || (a.src == b.src && a.dst < b.dst);
  endfunction

  // Update the arc table for one request and queue the result items it causes.
  function automatic void apply_arc_request(sat_req_e kind, logic [KeyW-1:0] from_key,
                                            logic [KeyW-1:0] to_key);
    arc_t        fresh;
    int unsigned slot;
    int unsigned idx;
    int unsigned hits;
    if (kind == REQ_INSERT) begin
      if (arc_total >= TABLE_DEPTH) begin
        queue_result(make_result(STATUS_FULL, '0, '0, 1'b1));
        return;
      end
      fresh.src = from_key;
      fresh.dst = to_key;
      // land after every equal or smaller arc so equal arcs keep arrival order
      slot = 0;
      while (slot < arc_total && !sorts_before(fresh, arc_tab[slot])) slot++;
      for (idx = arc_total; idx > slot; idx--) arc_tab[idx] = arc_tab[idx - 1];
      arc_tab[slot] = fresh;
      arc_total++;
      queue_result(make_result(STATUS_INSERTED, '0, '0, 1'b1));
      return;
    end
    slot = 0;
    while (slot < arc_total && arc_tab[slot].src < from_key) slot++;
    hits = 0;
    while (slot < arc_total && arc_tab[slot].src[KeyW-1:KeyW-VertW] ==
           from_key[KeyW-1:KeyW-VertW]) begin
      queue_result(make_result(STATUS_MATCH, arc_tab[slot].src,
                               arc_tab[slot].dst, 1'b0));
      slot++;
      hits++;
    end
    if (hits == 0) queue_result(make_result(STATUS_NOMATCH, '0, '0, 1'b1));
    else results_due_q[results_due_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    sat_rsp_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (results_due_q.size() == 0) begin
          $error("unexpected result item: status %0d source %h target %h last %0b",
                 rsp_i.status, rsp_i.arc_source, rsp_i.arc_target, rsp_i.last);
          mismatch_cnt++;
        end else begin
          want = results_due_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            mismatch_cnt++;
          end
          if (rsp_i.arc_source !== want.arc_source) begin
            $error("arc_source: expected %h, got %h", want.arc_source, rsp_i.arc_source);
            mismatch_cnt++;
          end
          if (rsp_i.arc_target !== want.arc_target) begin
            $error("arc_target: expected %h, got %h", want.arc_target, rsp_i.arc_target);
            mismatch_cnt++;
          end
          if (rsp_i.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp_i.last);
            mismatch_cnt++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_arc_request(sat_req_e'(req_i.req_type), req_i.from_key, req_i.to_key);
      end
      due_cnt = results_due_q.size();
    end
  end

endmodule

[sim/tb_sorted_arc_table_unit.sv]
// Testbench top of the sorted arc table: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 100ps

module tb_sorted_arc_table_unit import sat_pkg::*; ();

  localparam int unsigned TableDepth  = 64;
  localparam int unsigned RandomItems = 150;
  // cycles with no item moving on either channel before the run is called hung;
  // the slowest correct gap is a sender gap, a full-table scan and a result stall
  localparam int unsigned IdleLimit   = 4000;
  // drain time after the last result: one full insert scan and then some
  localparam int unsigned TailCycles  = 80;

  logic        clk_i;
  logic        rst_ni;
  bit          quiet_phase;
  int unsigned inserts_sent;
  int unsigned mismatches;
  int unsigned results_due;
  logic [63:0] last_from;
  logic [63:0] last_to;

  sat_req_if req_if ();
  sat_rsp_if rsp_if ();

  sorted_arc_table_unit #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  sat_arc_monitor #(
    .TABLE_DEPTH(TableDepth)
  ) u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .mismatch_cnt_o(mismatches),
    .results_due_o (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gap before the next item on either side; quiet stretches run back to back.
  function automatic int unsigned pick_gap();
    return quiet_phase ? 0 : $urandom_range(0, 19);
  endfunction

  // Vertices cluster on a few small values so queries find real runs of arcs,
  // with the extremes and fully random vertices mixed in.
  function automatic logic [31:0] pick_vertex();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 32'd3 + $urandom_range(0, 5);
    if (roll == 6) return '1;
    if (roll == 7) return '0;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom_range(0, 15);
    if (roll == 5) return '0;
    if (roll == 6) return '1;
    return $urandom();
  endfunction

  function automatic logic [63:0] pick_key();
    return {pick_vertex(), pick_position()};
  endfunction

  // Targets: structured keys, a repeat of the last target (equal source keys
  // then sort on target), or anything at all.
  function automatic logic [63:0] pick_target();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return pick_key();
    if (roll == 3) return last_to;
    return {$urandom(), $urandom()};
  endfunction

  // Present one request item after a random gap and hold it until accepted.
  // Valid stays high into the next item when that one has no gap.
  task automatic send_req(input sat_req_e kind, input logic [63:0] from_key,
                          input logic [63:0] to_key);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.from_key <= from_key;
    req_if.to_key   <= to_key;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    if (kind == REQ_INSERT) inserts_sent++;
  endtask

  // Drop valid and hold off until every expected result item has come back.
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
  endtask

  // Result side: stall a random number of cycles before each item.
  initial begin
    int unsigned hold;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("sorted_arc_table_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned n;
    quiet_phase     = 1'b0;
    inserts_sent    = 0;
    last_from       = '0;
    last_to         = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_INSERT;
    req_if.from_key = '0;
    req_if.to_key   = '0;
    rst_ni          = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    // query an empty table; the all-ones target must not matter
    send_req(REQ_QUERY, {32'd5, 32'd0}, '1);
    // a run on vertex 5 with equal arcs and an equal source with a smaller target
    send_req(REQ_INSERT, {32'd5, 32'd10}, {32'd9, 32'd1});
    send_req(REQ_INSERT, {32'd5, 32'd10}, {32'd9, 32'd1});
    send_req(REQ_INSERT, {32'd5, 32'd10}, {32'd2, 32'd7});
    send_req(REQ_INSERT, {32'd5, 32'd3}, '1);
    // the next vertex at position 0 with target 0 must stay outside a vertex 5 range
    send_req(REQ_INSERT, {32'd6, 32'd0}, '0);
    send_req(REQ_INSERT, {32'd4, 32'hFFFF_FFFF}, {32'd5, 32'd0});
    // highest vertex and the all-zero arc: a highest-vertex range must not wrap
    send_req(REQ_INSERT, '1, '1);
    send_req(REQ_INSERT, {32'hFFFF_FFFF, 32'd0}, '0);
    send_req(REQ_INSERT, '0, '0);
    send_req(REQ_QUERY, {32'd5, 32'd0}, '1);
    send_req(REQ_QUERY, {32'd5, 32'd10}, '0);
    send_req(REQ_QUERY, {32'd5, 32'd11}, {$urandom(), $urandom()});
    send_req(REQ_QUERY, {32'd5, 32'hFFFF_FFFF}, '0);
    send_req(REQ_QUERY, {32'hFFFF_FFFF, 32'd0}, '0);
    send_req(REQ_QUERY, '1, '0);
    send_req(REQ_QUERY, '0, '1);
    send_req(REQ_QUERY, {32'd6, 32'd0}, '0);
    send_req(REQ_QUERY, {32'd4, 32'd0}, {$urandom(), $urandom()});
    send_req(REQ_QUERY, {32'd7, 32'd0}, '0);

    // Random part: inserts and queries half and half; every third block of
    // items runs with no gaps on either side.
    for (n = 0; n < RandomItems; n++) begin
      if (n % 25 == 0) quiet_phase = ((n / 25) % 3 == 1);
      // halfway through, hold off until every result item is back
      if (n == RandomItems / 2) drain_results();
      if ($urandom_range(0, 1) == 0) begin
        // now and then repeat the previous arc exactly
        if ($urandom_range(0, 7) != 0) begin
          last_from = pick_key();
          last_to   = pick_target();
        end
        send_req(REQ_INSERT, last_from, last_to);
      end else begin
        send_req(REQ_QUERY, pick_key(), {$urandom(), $urandom()});
      end
    end

    // Fill the table and push past it so the full case is always reached,
    // then query the full table.
    quiet_phase = 1'b0;
    while (inserts_sent < TableDepth + 2) send_req(REQ_INSERT, pick_key(), pick_target());
    send_req(REQ_QUERY, {32'd3, 32'd0}, '1);
    send_req(REQ_QUERY, {32'hFFFF_FFFF, 32'd0}, '0);

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("sorted_arc_table_unit regression: pass");
    end else begin
      $display("sorted_arc_table_unit regression: fail");
    end
    $finish;
  end

endmodule
